// ----- rtl/awpf_pkg.sv -----
// Shared types and constants for the weighted-feature arg-max unit.
package awpf_pkg;

  // Field widths fixed by the interface.
  localparam int SCORE_W   = 48;
  localparam int FEAT_W    = 16;
  localparam int WEIGHT_W  = 32;
  localparam int PROD_W    = WEIGHT_W + FEAT_W;
  localparam int PAIR_W    = PROD_W + 1;
  localparam int SUM_W     = PAIR_W + 2;
  localparam int IDX_W     = 12;
  localparam int CFG_IDX_W = 3;

  // Run limits and term count.
  localparam int MAX_CANDIDATES = 4096;
  localparam int CNT_W          = $clog2(MAX_CANDIDATES + 1);
  localparam int NUM_TERMS      = 4;
  localparam int TERM_SLOTS     = 4;

  // Depth of the queue between front and back.
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1) + 1;

  // Saturation bounds of a score.
  localparam logic signed [SCORE_W-1:0] SCORE_MAXV = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SCORE_W-1:0] SCORE_MINV = {1'b1, {(SCORE_W-1){1'b0}}};

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_ZERO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_ONE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_TWO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_THREE = 3'd3;

  // One input word.
  typedef struct packed {
    logic signed [SCORE_W-1:0] unary_score;
    logic signed [FEAT_W-1:0]  feature_zero;
    logic signed [FEAT_W-1:0]  feature_one;
    logic signed [FEAT_W-1:0]  feature_two;
    logic signed [FEAT_W-1:0]  feature_three;
    logic                      is_last;
  } in_item_t;

  // One result word.
  typedef struct packed {
    logic signed [SCORE_W-1:0] best_score;
    logic [IDX_W-1:0]          best_index;
    logic                      count_overflow;
  } out_item_t;

  // A scored candidate as it travels from front to back.
  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      is_last;
  } score_item_t;

  // Configuration write.
  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [WEIGHT_W-1:0]  data;
  } cfg_wr_t;

  // Push from the front into the queue.
  typedef struct packed {
    logic        valid;
    score_item_t item;
  } q_push_t;

  // Head of the queue as seen by the back.
  typedef struct packed {
    logic        valid;
    score_item_t item;
  } q_head_t;

  // Fill level reported to the front for admission.
  typedef struct packed {
    logic [QCNT_W-1:0] count;
  } q_status_t;

endpackage

// ----- rtl/argmax_unary_plus_weighted_features_unit.sv -----
// Top level of the streaming weighted-feature arg-max unit.
//
// Each input word on in_data is one candidate: a unary score, four signed
// feature terms and an end-of-run mark. Its score is the unary plus the
// weighted features, saturated to 48 bits. At the marked last word the unit
// presents one result word on out_data with the best score, the index of the
// first candidate that reached it and an overflow flag, then starts a new run.
// Weights are written on the cfg port (index 0..3); the user must write them
// only while the unit is idle, which the unit does not enforce. Other indexes
// are ignored. cfg_ready is always high. Throughput is one word per cycle
// while in_ready is high, set by the product and sum pipeline, which issues
// one candidate per clock. A last word accepted when the queue is empty
// passes from the product stage through the pair sums, the queue write and
// the result register before out_valid rises.
// When the receiver stalls, the result register holds; the back keeps
// consuming non-last words, and the four-entry queue fills until in_ready
// drops. Synchronous reset clears weights, run state and all valids.
module argmax_unary_plus_weighted_features_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [awpf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [awpf_pkg::WEIGHT_W-1:0]     cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  awpf_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output awpf_pkg::out_item_t               out_data
);

  awpf_pkg::cfg_wr_t   cfg_wr;
  awpf_pkg::q_push_t   q_push;
  awpf_pkg::q_head_t   q_head;
  awpf_pkg::q_status_t q_stat;
  logic                q_pop;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  // Scoring front end.
  awpf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_wr),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_push   (q_push)
  );

  // Decoupling queue.
  awpf_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_pop  (q_pop),
    .q_head (q_head),
    .q_stat (q_stat)
  );

  // Arg-max back end.
  awpf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The queue never holds more than its depth.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= awpf_pkg::QCNT_W'(awpf_pkg::QDEPTH))
    else $error("queue fill level exceeds its depth");

  // Admission control leaves no word in flight when the queue is full.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (q_stat.count == awpf_pkg::QCNT_W'(awpf_pkg::QDEPTH)) |-> !q_push.valid)
    else $error("push into a full queue");

  // A pop only ever takes a valid head word.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head.valid)
    else $error("pop from an empty queue");

endmodule

// ----- rtl/awpf_front.sv -----
// Front: weight registers, product and sum pipeline with saturation.
module awpf_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  awpf_pkg::cfg_wr_t     cfg_wr,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  awpf_pkg::in_item_t    in_data,
  input  awpf_pkg::q_status_t   q_stat,
  output awpf_pkg::q_push_t     q_push
);

  logic signed [awpf_pkg::WEIGHT_W-1:0] weight_r [awpf_pkg::TERM_SLOTS];
  logic signed [awpf_pkg::FEAT_W-1:0]   feat     [awpf_pkg::TERM_SLOTS];

  // Stage one: products.
  logic                                v1_r;
  logic signed [awpf_pkg::PROD_W-1:0]  prod_r  [awpf_pkg::TERM_SLOTS];
  logic signed [awpf_pkg::PROD_W-1:0]  prod_nxt[awpf_pkg::TERM_SLOTS];
  logic signed [awpf_pkg::SCORE_W-1:0] unary1_r;
  logic                                last1_r;

  // Stage two: pair sums.
  logic                                v2_r;
  logic signed [awpf_pkg::PAIR_W-1:0]  s01_r;
  logic signed [awpf_pkg::PAIR_W-1:0]  s23_r;
  logic signed [awpf_pkg::SCORE_W-1:0] unary2_r;
  logic                                last2_r;

  logic signed [awpf_pkg::SUM_W-1:0]   total;
  logic signed [awpf_pkg::SCORE_W-1:0] sat_score;
  logic [awpf_pkg::QCNT_W-1:0]         committed;
  logic                                accept;

  // Weight registers are written from the configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < awpf_pkg::TERM_SLOTS; k++) begin
        weight_r[k] <= '0;
      end
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        awpf_pkg::REG_WEIGHT_ZERO:  weight_r[0] <= cfg_wr.data;
        awpf_pkg::REG_WEIGHT_ONE:   weight_r[1] <= cfg_wr.data;
        awpf_pkg::REG_WEIGHT_TWO:   weight_r[2] <= cfg_wr.data;
        awpf_pkg::REG_WEIGHT_THREE: weight_r[3] <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // Admit a word only when the queue can absorb everything in flight.
  assign committed = q_stat.count + awpf_pkg::QCNT_W'(v1_r) + awpf_pkg::QCNT_W'(v2_r);
  assign in_ready  = (committed < awpf_pkg::QCNT_W'(awpf_pkg::QDEPTH));
  assign accept    = in_valid && in_ready;

  assign feat[0] = in_data.feature_zero;
  assign feat[1] = in_data.feature_one;
  assign feat[2] = in_data.feature_two;
  assign feat[3] = in_data.feature_three;

  // Four independent multiplies; terms past the configured count drop out.
  always_comb begin
    for (int k = 0; k < awpf_pkg::TERM_SLOTS; k++) begin
      if (k < awpf_pkg::NUM_TERMS) begin
        prod_nxt[k] = awpf_pkg::PROD_W'(weight_r[k]) * awpf_pkg::PROD_W'(feat[k]);
      end else begin
        prod_nxt[k] = '0;
      end
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    for (int k = 0; k < awpf_pkg::TERM_SLOTS; k++) begin
      prod_r[k] <= prod_nxt[k];
    end
    unary1_r <= in_data.unary_score;
    last1_r  <= in_data.is_last;
    s01_r    <= awpf_pkg::PAIR_W'(prod_r[0]) + awpf_pkg::PAIR_W'(prod_r[1]);
    s23_r    <= awpf_pkg::PAIR_W'(prod_r[2]) + awpf_pkg::PAIR_W'(prod_r[3]);
    unary2_r <= unary1_r;
    last2_r  <= last1_r;
  end

  // Final sum, clamped to the score range.
  always_comb begin
    total = awpf_pkg::SUM_W'(unary2_r) + awpf_pkg::SUM_W'(s01_r) + awpf_pkg::SUM_W'(s23_r);
    if (total > awpf_pkg::SUM_W'(awpf_pkg::SCORE_MAXV)) begin
      sat_score = awpf_pkg::SCORE_MAXV;
    end else if (total < awpf_pkg::SUM_W'(awpf_pkg::SCORE_MINV)) begin
      sat_score = awpf_pkg::SCORE_MINV;
    end else begin
      sat_score = total[awpf_pkg::SCORE_W-1:0];
    end
  end

  assign q_push.valid        = v2_r;
  assign q_push.item.score   = sat_score;
  assign q_push.item.is_last = last2_r;

endmodule

// ----- rtl/awpf_queue.sv -----
// Short queue of scored candidates between front and back.
module awpf_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  awpf_pkg::q_push_t     q_push,
  input  logic                  q_pop,
  output awpf_pkg::q_head_t     q_head,
  output awpf_pkg::q_status_t   q_stat
);

  awpf_pkg::score_item_t          mem_r [awpf_pkg::QDEPTH];
  logic [awpf_pkg::QPTR_W-1:0]    head_r;
  logic [awpf_pkg::QPTR_W-1:0]    tail_r;
  logic [awpf_pkg::QCNT_W-1:0]    count_r;
  logic [awpf_pkg::QCNT_W-1:0]    count_nxt;

  // Storage is written at the tail.
  always_ff @(posedge clk) begin
    if (q_push.valid) begin
      mem_r[tail_r] <= q_push.item;
    end
  end

  assign count_nxt = count_r + awpf_pkg::QCNT_W'(q_push.valid)
                     - awpf_pkg::QCNT_W'(q_pop);

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (q_push.valid) begin
        tail_r <= tail_r + awpf_pkg::QPTR_W'(1);
      end
      if (q_pop) begin
        head_r <= head_r + awpf_pkg::QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  assign q_head.valid = (count_r != '0);
  assign q_head.item  = mem_r[head_r];
  assign q_stat.count = count_r;

endmodule

// ----- rtl/awpf_back.sv -----
// Back: running maximum, index tracking and the result register.
module awpf_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  awpf_pkg::q_head_t     q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output awpf_pkg::out_item_t   out_data
);

  logic signed [awpf_pkg::SCORE_W-1:0] running_max_r, running_max_nxt;
  logic [awpf_pkg::IDX_W-1:0]          running_index_r, running_index_nxt;
  logic [awpf_pkg::CNT_W-1:0]          count_r, count_nxt;
  logic                                overflow_r, overflow_nxt;
  logic                                out_valid_r, out_valid_nxt;
  awpf_pkg::out_item_t                 out_data_r, out_data_nxt;

  // A last word waits only while the result register is still full.
  assign q_pop = q_head.valid &&
                 (!q_head.item.is_last || !out_valid_r || out_ready);

  // Compare and update for the popped candidate.
  always_comb begin
    running_max_nxt   = running_max_r;
    running_index_nxt = running_index_r;
    count_nxt         = count_r;
    overflow_nxt      = overflow_r;
    out_data_nxt      = out_data_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    if (q_pop) begin
      if (count_r >= awpf_pkg::CNT_W'(awpf_pkg::MAX_CANDIDATES)) begin
        overflow_nxt = 1'b1;
      end else begin
        if (count_r == '0 || q_head.item.score > running_max_r) begin
          running_max_nxt   = q_head.item.score;
          running_index_nxt = awpf_pkg::IDX_W'(count_r);
        end
        count_nxt = count_r + awpf_pkg::CNT_W'(1);
      end
      if (q_head.item.is_last) begin
        out_data_nxt.best_score     = running_max_nxt;
        out_data_nxt.best_index     = running_index_nxt;
        out_data_nxt.count_overflow = overflow_nxt;
        out_valid_nxt               = 1'b1;
        running_max_nxt             = awpf_pkg::SCORE_MINV;
        running_index_nxt           = '0;
        count_nxt                   = '0;
        overflow_nxt                = 1'b0;
      end
    end
  end

  // Run state and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_max_r   <= awpf_pkg::SCORE_MINV;
      running_index_r <= '0;
      count_r         <= '0;
      overflow_r      <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      running_max_r   <= running_max_nxt;
      running_index_r <= running_index_nxt;
      count_r         <= count_nxt;
      overflow_r      <= overflow_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
